FILE: sv/dnsa_pkg.sv
// ----------------------------------------------------------------------------
// dnsa_pkg
// Shared constants and types for the DNS A-record address extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package dnsa_pkg;

  localparam int HEADER_BYTES  = 12;
  localparam int Q_FIXED_BYTES = 4;
  localparam int A_FIXED_BYTES = 10;
  localparam int ADDR_BYTES    = 4;

  localparam int SKIP_W = 4;

  // Last count value of each fixed-length run of bytes.
  localparam logic [SKIP_W-1:0] HDR_LAST    = SKIP_W'(HEADER_BYTES - 1);
  localparam logic [SKIP_W-1:0] QFIXED_LAST = SKIP_W'(Q_FIXED_BYTES - 1);
  localparam logic [SKIP_W-1:0] AFIXED_LAST = SKIP_W'(A_FIXED_BYTES - 1);
  localparam logic [SKIP_W-1:0] ADDR_LAST   = SKIP_W'(ADDR_BYTES - 1);

  localparam logic [1:0] PTR_MARK = 2'b11;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_TRUNC = 1'b1;

  typedef struct packed {
    logic [31:0] ip_address;
    logic        status;
  } dnsa_result_t;

endpackage

`default_nettype wire

FILE: sv/dnsa_parser.sv
// ----------------------------------------------------------------------------
// dnsa_parser
// Byte-wise walk of a DNS response up to the first answer's IPv4 address.
// ----------------------------------------------------------------------------
`default_nettype none

module dnsa_parser (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step,
  input  wire logic [7:0]            data_byte,
  input  wire logic                  end_of_message,
  output logic                       res_valid,
  output dnsa_pkg::dnsa_result_t     res
);

  import dnsa_pkg::*;

  typedef enum logic [3:0] {
    PH_HEADER,
    PH_QLEN,
    PH_QLABEL,
    PH_QFIXED,
    PH_ANAME,
    PH_APTR,
    PH_ALABEL,
    PH_ALEN,
    PH_AFIXED,
    PH_ADDR,
    PH_DONE
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [SKIP_W-1:0]   skip_r, skip_nxt;
  logic [7:0]          label_r, label_nxt;
  logic [23:0]         acc_r, acc_nxt;
  logic                given_r, given_nxt;
  logic                hit_addr, hit_err;
  logic [7:0]          label_dec;

  assign label_dec = label_r - 8'd1;

  always_comb begin
    phase_nxt = phase_r;
    skip_nxt  = skip_r;
    label_nxt = label_r;
    acc_nxt   = acc_r;
    given_nxt = given_r;
    hit_addr  = 1'b0;
    hit_err   = 1'b0;

    case (phase_r)
      PH_HEADER: begin
        skip_nxt = skip_r + 1'b1;
        if (skip_r == HDR_LAST) begin
          skip_nxt  = '0;
          phase_nxt = PH_QLEN;
        end
      end
      PH_QLEN: begin
        if (data_byte == 8'd0) begin
          skip_nxt  = '0;
          phase_nxt = PH_QFIXED;
        end else begin
          label_nxt = data_byte;
          phase_nxt = PH_QLABEL;
        end
      end
      PH_QLABEL: begin
        label_nxt = label_dec;
        if (label_dec == 8'd0) phase_nxt = PH_QLEN;
      end
      PH_QFIXED: begin
        skip_nxt = skip_r + 1'b1;
        if (skip_r == QFIXED_LAST) begin
          skip_nxt  = '0;
          phase_nxt = PH_ANAME;
        end
      end
      PH_ANAME: begin
        // Any first byte with both top bits set opens a compression pointer.
        if (data_byte[7:6] == PTR_MARK) begin
          phase_nxt = PH_APTR;
        end else if (data_byte == 8'd0) begin
          skip_nxt  = '0;
          phase_nxt = PH_AFIXED;
        end else begin
          label_nxt = data_byte;
          phase_nxt = PH_ALABEL;
        end
      end
      PH_APTR: begin
        skip_nxt  = '0;
        phase_nxt = PH_AFIXED;
      end
      PH_ALABEL: begin
        label_nxt = label_dec;
        if (label_dec == 8'd0) phase_nxt = PH_ALEN;
      end
      PH_ALEN: begin
        if (data_byte == 8'd0) begin
          skip_nxt  = '0;
          phase_nxt = PH_AFIXED;
        end else begin
          label_nxt = data_byte;
          phase_nxt = PH_ALABEL;
        end
      end
      PH_AFIXED: begin
        skip_nxt = skip_r + 1'b1;
        if (skip_r == AFIXED_LAST) begin
          skip_nxt  = '0;
          phase_nxt = PH_ADDR;
        end
      end
      PH_ADDR: begin
        // Only the first three octets are kept; the fourth is the byte in hand.
        acc_nxt  = {acc_r[15:0], data_byte};
        skip_nxt = skip_r + 1'b1;
        if (skip_r == ADDR_LAST) begin
          hit_addr  = 1'b1;
          given_nxt = 1'b1;
          skip_nxt  = '0;
          phase_nxt = PH_DONE;
        end
      end
      default: begin
      end
    endcase

    if (end_of_message) begin
      hit_err   = ~given_nxt;
      phase_nxt = PH_HEADER;
      skip_nxt  = '0;
      label_nxt = '0;
      given_nxt = 1'b0;
    end
  end

  assign res_valid      = hit_addr | hit_err;
  assign res.ip_address = hit_err ? 32'd0 : {acc_r, data_byte};
  assign res.status     = hit_err ? STATUS_TRUNC : STATUS_OK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      skip_r  <= '0;
      label_r <= '0;
      given_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      skip_r  <= skip_nxt;
      label_r <= label_nxt;
      given_r <= given_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/dns_a_record_address_extract.sv
// ----------------------------------------------------------------------------
// dns_a_record_address_extract
// Extracts the IPv4 address of the first answer from a byte-wide DNS response.
// ----------------------------------------------------------------------------
// Bytes of a DNS response enter one per cycle, with end_of_message marking the
// last byte. Each transfer lands in an input register and is parsed from there
// into an output register, so a byte enters every cycle while the result side
// keeps up; the only hold-off is a pending result that out_ready has not yet
// taken. One result leaves per message: the address with status 0 when four
// data bytes of the first answer were seen, otherwise status 1 and address 0
// on the final byte.
`default_nettype none

module dns_a_record_address_extract (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_message,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_ip_address,
  output logic             out_status
);

  import dnsa_pkg::*;

  logic         in_valid_r;
  logic [7:0]   byte_r;
  logic         eom_r;
  logic         out_valid_r;
  dnsa_result_t out_r;
  logic         res_valid;
  dnsa_result_t res;
  logic         advance;

  // A byte that yields no result may pass even while the output is full.
  assign advance  = in_valid_r & (~res_valid | ~out_valid_r | out_ready);
  assign in_ready = ~in_valid_r | advance;

  dnsa_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (advance),
    .data_byte      (byte_r),
    .end_of_message (eom_r),
    .res_valid      (res_valid),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) in_valid_r <= in_valid;
      if (advance && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_data_byte;
      eom_r  <= in_end_of_message;
    end
    if (advance && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ip_address = out_r.ip_address;
  assign out_status     = out_r.status;

endmodule

`default_nettype wire

FILE: sv/dnsa_checker.sv
// ----------------------------------------------------------------------------
// dnsa_checker
// Port-level checks of the DNS A-record address extractor, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module dnsa_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_ip_address,
  input wire logic        out_status
);

  import dnsa_pkg::*;

  // A result waiting on the consumer is held unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ip_address) && $stable(out_status))
    else $error("result changed while stalled");

  // An error result never carries an address.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_TRUNC |-> out_ip_address == 32'd0)
    else $error("error result with nonzero address");

  // Reset empties the output side.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // With the output empty the input side is never held off.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind dns_a_record_address_extract dnsa_checker u_dnsa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_ip_address (out_ip_address),
  .out_status     (out_status)
);

`default_nettype wire
